// File: rtl/tnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal and centroid package
// Shared widths, constants and the record that travels down the divider pipe.
// ----------------------------------------------------------------------------
package tnc_pkg;

   localparam int AXES             = 3;
   localparam int COORD_WIDTH      = 16;
   localparam int EDGE_W           = COORD_WIDTH + 1;
   localparam int SUM_W            = COORD_WIDTH + 2;
   localparam int PROD_W           = 2 * EDGE_W;
   localparam int CROSS_W          = PROD_W + 1;
   localparam int MAG_W            = PROD_W;
   localparam int LIM_W            = 31;
   localparam int SHIFT_W          = 2;
   localparam int SQ_W             = 2 * LIM_W;
   localparam int SUMSQ_W          = 64;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NORMAL_W         = 16;
   localparam int REM_SHIFT        = 2 * NORMAL_FRAC_BITS + 2;
   localparam int REM_W            = 100;
   localparam int ACC_W            = 80;
   localparam int QUO_W            = NORMAL_FRAC_BITS + 1;
   localparam int STEPS            = NORMAL_FRAC_BITS + 1;
   localparam int STEP_BIT_W       = 4;

   // Division by three: floor(n / 3) == (n * RECIP3) >> RECIP3_SHIFT for n < 2^17.
   localparam int CMAG_W           = SUM_W - 1;
   localparam int RECIP3_W         = 17;
   localparam int CPROD_W          = CMAG_W + RECIP3_W;
   localparam logic [RECIP3_W-1:0] RECIP3 = 17'd87382;
   localparam int RECIP3_SHIFT     = 18;

   typedef struct packed {
      logic [AXES-1:0][REM_W-1:0]       rem;
      logic [AXES-1:0][ACC_W-1:0]       acc;
      logic [AXES-1:0][QUO_W-1:0]       quo;
      logic [SUMSQ_W-1:0]               sum_sq;
      logic [AXES-1:0]                  neg;
      logic                             degen;
      logic [AXES-1:0][COORD_WIDTH-1:0] center;
   } tnc_iter_type;

endpackage

// File: rtl/tnc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle front end
// Six stages: edges, products, cross product and centroid, range reduction,
// squares, and the setup of the normalizing divide.
// ----------------------------------------------------------------------------
module tnc_front import tnc_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             up_valid,
   output logic                             up_ready,
   input  logic [AXES-1:0][COORD_WIDTH-1:0] vert_a,
   input  logic [AXES-1:0][COORD_WIDTH-1:0] vert_b,
   input  logic [AXES-1:0][COORD_WIDTH-1:0] vert_c,
   output logic                             down_valid,
   input  logic                             down_ready,
   output tnc_iter_type                     down_data
);

   logic [5:0] valid_ff;
   logic [6:0] rdy;

   logic signed [EDGE_W-1:0]  e1_ff [AXES], e1_in [AXES];
   logic signed [EDGE_W-1:0]  e2_ff [AXES], e2_in [AXES];
   logic signed [SUM_W-1:0]   csum_ff [AXES], csum_in [AXES];

   logic signed [PROD_W-1:0]  pa_ff [AXES], pa_in [AXES];
   logic signed [PROD_W-1:0]  pb_ff [AXES], pb_in [AXES];
   logic [COORD_WIDTH-1:0]    cquo_ff [AXES], cquo_in [AXES];
   logic [AXES-1:0]           cneg_ff, cneg_in;
   logic [CMAG_W-1:0]         cmag [AXES];
   logic [CPROD_W-1:0]        cprod [AXES];

   logic signed [CROSS_W-1:0] cross_vec [AXES];
   logic [MAG_W-1:0]          mag3_ff [AXES], mag3_in [AXES];
   logic [AXES-1:0]           neg3_ff, neg3_in;
   logic [AXES-1:0][COORD_WIDTH-1:0] ctr3_ff, ctr3_in;

   logic [MAG_W-1:0]          mag_or;
   logic [SHIFT_W-1:0]        sh;
   logic [LIM_W-1:0]          norm4_ff [AXES], norm4_in [AXES];
   logic [AXES-1:0]           neg4_ff;
   logic                      degen4_ff, degen4_in;
   logic [AXES-1:0][COORD_WIDTH-1:0] ctr4_ff;

   logic [SQ_W-1:0]           sq5_ff [AXES], sq5_in [AXES];
   logic [AXES-1:0]           neg5_ff;
   logic                      degen5_ff;
   logic [AXES-1:0][COORD_WIDTH-1:0] ctr5_ff;

   tnc_iter_type              out_ff, out_in;
   logic [SUMSQ_W-1:0]        sum_sq;

   // A stage takes a new transaction when it is empty or its successor moves.
   always_comb begin
      rdy[6] = down_ready;
      for (int i = 5; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end
   assign up_ready   = rdy[0];
   assign down_valid = valid_ff[5];
   assign down_data  = out_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         e1_in[i]   = EDGE_W'($signed(vert_b[i])) - EDGE_W'($signed(vert_a[i]));
         e2_in[i]   = EDGE_W'($signed(vert_c[i])) - EDGE_W'($signed(vert_a[i]));
         csum_in[i] = SUM_W'($signed(vert_a[i])) + SUM_W'($signed(vert_b[i]))
                    + SUM_W'($signed(vert_c[i]));
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         pa_in[i]   = PROD_W'(e1_ff[(i+1)%AXES]) * PROD_W'(e2_ff[(i+2)%AXES]);
         pb_in[i]   = PROD_W'(e1_ff[(i+2)%AXES]) * PROD_W'(e2_ff[(i+1)%AXES]);
         cneg_in[i] = csum_ff[i][SUM_W-1];
         cmag[i]    = cneg_in[i] ? CMAG_W'(-csum_ff[i]) : CMAG_W'(csum_ff[i]);
         cprod[i]   = CPROD_W'(cmag[i]) * CPROD_W'(RECIP3);
         cquo_in[i] = COORD_WIDTH'(cprod[i] >> RECIP3_SHIFT);
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         cross_vec[i] = CROSS_W'(pa_ff[i]) - CROSS_W'(pb_ff[i]);
         neg3_in[i]   = cross_vec[i][CROSS_W-1];
         mag3_in[i]   = neg3_in[i] ? MAG_W'(-cross_vec[i]) : MAG_W'(cross_vec[i]);
         ctr3_in[i]   = cneg_ff[i] ? -cquo_ff[i] : cquo_ff[i];
      end
   end

   // Shift all three magnitudes alike so that the largest fits in LIM_W bits.
   always_comb begin
      mag_or = mag3_ff[0] | mag3_ff[1] | mag3_ff[2];
      sh     = '0;
      for (int j = LIM_W; j < MAG_W; j++) begin
         if (mag_or[j]) begin
            sh = SHIFT_W'(j - LIM_W + 1);
         end
      end
      degen4_in = (mag_or == '0);
      for (int i = 0; i < AXES; i++) begin
         norm4_in[i] = LIM_W'(mag3_ff[i] >> sh);
      end
   end

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sq5_in[i] = SQ_W'(norm4_ff[i]) * SQ_W'(norm4_ff[i]);
      end
   end

   always_comb begin
      sum_sq = SUMSQ_W'(sq5_ff[0]) + SUMSQ_W'(sq5_ff[1]) + SUMSQ_W'(sq5_ff[2]);
      out_in = '0;
      out_in.sum_sq = sum_sq;
      out_in.neg    = neg5_ff;
      out_in.degen  = degen5_ff;
      out_in.center = ctr5_ff;
      for (int i = 0; i < AXES; i++) begin
         out_in.rem[i] = (REM_W'(sq5_ff[i]) << REM_SHIFT) - REM_W'(sum_sq);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= up_valid;
         end
         for (int k = 1; k < 6; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         e1_ff   <= e1_in;
         e2_ff   <= e2_in;
         csum_ff <= csum_in;
      end
      if (rdy[1]) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         cquo_ff <= cquo_in;
         cneg_ff <= cneg_in;
      end
      if (rdy[2]) begin
         mag3_ff <= mag3_in;
         neg3_ff <= neg3_in;
         ctr3_ff <= ctr3_in;
      end
      if (rdy[3]) begin
         norm4_ff  <= norm4_in;
         neg4_ff   <= neg3_ff;
         degen4_ff <= degen4_in;
         ctr4_ff   <= ctr3_ff;
      end
      if (rdy[4]) begin
         sq5_ff    <= sq5_in;
         neg5_ff   <= neg4_ff;
         degen5_ff <= degen4_ff;
         ctr5_ff   <= ctr4_ff;
      end
      if (rdy[5]) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: rtl/tnc_norm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Normal divide step
// Decides one quotient bit of all three normal components and registers it.
// ----------------------------------------------------------------------------
module tnc_norm_step import tnc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [STEP_BIT_W-1:0] step_bit,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  tnc_iter_type          up_data,
   output logic                  down_valid,
   input  logic                  down_ready,
   output tnc_iter_type          down_data
);

   logic         valid_ff;
   tnc_iter_type data_ff, data_in;
   logic [REM_W-1:0] sum_w;
   logic [REM_W-1:0] delta [AXES];
   logic [AXES-1:0]  take;

   // The residual holds R - (2m-1)^2 * S and acc holds m * S. Raising m by
   // b = 2^step_bit grows (2m-1)^2 * S by 4b * (2 * acc + (b - 1) * S).
   always_comb begin
      data_in = up_data;
      sum_w   = REM_W'(up_data.sum_sq);
      for (int i = 0; i < AXES; i++) begin
         delta[i] = ((REM_W'(up_data.acc[i]) << 1) + (sum_w << step_bit) - sum_w)
                    << (step_bit + 2);
         take[i]  = $signed(delta[i]) <= $signed(up_data.rem[i]);
         if (take[i]) begin
            data_in.rem[i]           = up_data.rem[i] - delta[i];
            data_in.acc[i]           = up_data.acc[i]
                                     + (ACC_W'(up_data.sum_sq) << step_bit);
            data_in.quo[i][step_bit] = 1'b1;
         end
      end
   end

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/triangle_normal_and_centroid_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal and centroid
// Unit normal (Q2.14), centroid (Q8.8) of one triangle per cycle unless stalled.
// ----------------------------------------------------------------------------
// From an accepted request to its response a transaction passes six front
// stages, fifteen divide steps (one quotient bit each) and the output register.
// Throughput is one transaction per cycle; a stalled response backs up the
// pipe stage by stage, so bubbles are squeezed out before the input stalls.
// Reset is synchronous and active high and clears only the valid bits.
module triangle_normal_and_centroid_top import tnc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_tdata, from bit 0 up: vertex_a_x, vertex_a_y, vertex_a_z,
   // vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z.
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rsp_tdata, from bit 0 up: normal_x, normal_y, normal_z,
   // center_x, center_y, center_z.
   output logic [95:0]  rsp_tdata,
   // rsp_tuser: degenerate.
   output logic         rsp_tuser
);

   tnc_iter_type chain_data  [STEPS+1];
   logic         chain_valid [STEPS+1];
   logic         chain_ready [STEPS+1];

   logic         rsp_valid_ff;
   logic [95:0]  rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff;
   logic [NORMAL_W-1:0] norm_mag [AXES];

   // The front end forms the exact cross product, scales it into 31 bits,
   // and sets up the remainder for the restoring divide by the length.
   tnc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_tvalid),
      .up_ready   (req_tready),
      .vert_a     (req_tdata[47:0]),
      .vert_b     (req_tdata[95:48]),
      .vert_c     (req_tdata[143:96]),
      .down_valid (chain_valid[0]),
      .down_ready (chain_ready[0]),
      .down_data  (chain_data[0])
   );

   // Each step settles one bit of the rounded quotient, most significant first.
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      tnc_norm_step u_step (
         .clock      (clock),
         .reset      (reset),
         .step_bit   (STEP_BIT_W'(NORMAL_FRAC_BITS - g)),
         .up_valid   (chain_valid[g]),
         .up_ready   (chain_ready[g]),
         .up_data    (chain_data[g]),
         .down_valid (chain_valid[g+1]),
         .down_ready (chain_ready[g+1]),
         .down_data  (chain_data[g+1])
      );
   end

   // The output register applies the sign and forces a zero normal when the
   // cross product vanished.
   assign chain_ready[STEPS] = !rsp_valid_ff || rsp_tready;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         norm_mag[i] = NORMAL_W'(chain_data[STEPS].quo[i]);
         if (chain_data[STEPS].degen) begin
            rsp_data_in[i*NORMAL_W +: NORMAL_W] = '0;
         end else if (chain_data[STEPS].neg[i]) begin
            rsp_data_in[i*NORMAL_W +: NORMAL_W] = -norm_mag[i];
         end else begin
            rsp_data_in[i*NORMAL_W +: NORMAL_W] = norm_mag[i];
         end
         rsp_data_in[AXES*NORMAL_W + i*COORD_WIDTH +: COORD_WIDTH] =
            chain_data[STEPS].center[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain_ready[STEPS]) begin
         rsp_valid_ff <= chain_valid[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[STEPS]) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= chain_data[STEPS].degen;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A degenerate triangle always reports a zero normal.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:0] == 48'd0)
      else $error("degenerate response with nonzero normal");

   // Every normal component stays within one unit.
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[15:0]) <= 16384 && $signed(rsp_tdata[15:0]) >= -16384 &&
         $signed(rsp_tdata[31:16]) <= 16384 && $signed(rsp_tdata[31:16]) >= -16384 &&
         $signed(rsp_tdata[47:32]) <= 16384 && $signed(rsp_tdata[47:32]) >= -16384)
      else $error("normal component out of range");

   // The input is only refused when the response side is stalled.
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled response");

endmodule

// File: dv/triangle_normal_and_centroid_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle normal and centroid testbench
// Streams directed and random triangles through the block with bursty input
// and a stalling receiver. Every response transaction is checked against a
// bit-exact prediction of the unit normal, centroid and degenerate flag.
// ----------------------------------------------------------------------------
module triangle_normal_and_centroid_top_tb import tnc_pkg::*;;

   // One predicted response: normals in Q2.14, centroid in Q8.8.
   typedef struct {
      logic [15:0] normal [3];
      logic [15:0] center [3];
      logic        degen;
   } face_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;

   logic [143:0]    pending_faces [$];
   face_result_type expected_faces [$];
   int              error_count = 0;

   // Sender burst and gap counters, receiver stall pattern counters.
   int burst_left = 0;
   int gap_left   = 0;
   int ready_left = 0;
   int ready_mode = 0;

   triangle_normal_and_centroid_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Exact face normal and centroid. The cross product is at most 35 bits
   // signed, so it is formed directly in 64-bit arithmetic. The magnitudes
   // are scaled down to 31 bits when needed, and each normal component is
   // found by a binary search on the rounded quotient, comparing squares so
   // that no square root is ever taken.
   function automatic face_result_type predict_face(logic [143:0] d);
      longint            v [9];
      longint            e1 [3];
      longint            e2 [3];
      longint            cr [3];
      longint unsigned   cm [3];
      longint unsigned   s;
      longint unsigned   lo;
      longint unsigned   hi;
      longint unsigned   mid;
      longint unsigned   t;
      logic [127:0]      rhs;
      logic [127:0]      lhs;
      int                ml;
      int                l;
      int                sh;
      face_result_type   r;
      for (int i = 0; i < 9; i++) begin
         v[i] = longint'($signed(d[16*i +: 16]));
      end
      for (int i = 0; i < 3; i++) begin
         e1[i] = v[3+i] - v[i];
         e2[i] = v[6+i] - v[i];
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      ml = 0;
      for (int i = 0; i < 3; i++) begin
         cm[i] = (cr[i] < 0) ? longint'(-cr[i]) : longint'(cr[i]);
         l = 0;
         while ((cm[i] >> l) != 0) l++;
         if (l > ml) ml = l;
      end
      r.degen = (ml == 0);
      sh = (ml > 31) ? ml - 31 : 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         cm[i] = cm[i] >> sh;
         s += cm[i] * cm[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (r.degen) begin
            r.normal[i] = '0;
         end else begin
            rhs = 128'(cm[i] * cm[i]) << (2 * NORMAL_FRAC_BITS + 2);
            lo = 0;
            hi = 64'd1 << NORMAL_FRAC_BITS;
            while (lo < hi) begin
               mid = lo + (hi - lo + 1) / 2;
               t = 2 * mid - 1;
               lhs = 128'(t * t) * 128'(s);
               if (lhs <= rhs) lo = mid;
               else hi = mid - 1;
            end
            r.normal[i] = (cr[i] < 0) ? 16'(-lo) : 16'(lo);
         end
         // SystemVerilog division truncates toward zero, as required here.
         r.center[i] = 16'((v[i] + v[3+i] + v[6+i]) / 3);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t",
               what, $signed(got), $signed(want), $realtime);
      error_count++;
   endtask

   task automatic add_face(int ax, int ay, int az, int bx, int by, int bz,
                           int cx, int cy, int cz);
      pending_faces.push_back({16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx),
                               16'(az), 16'(ay), 16'(ax)});
   endtask

   function automatic int rand_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   // Driver: the request is held while it waits for tready, and a new
   // transaction is loaded only once the current one has been accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_faces.push_back(predict_face(req_tdata));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_faces.size() > 0) begin
               req_tdata  <= pending_faces.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(40);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted response against the oldest prediction,
   // then picks the next tready from a pattern that alternates between
   // always-ready stretches, random stalls and long holds.
   always @(posedge clock) begin
      face_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_faces.size() == 0) begin
               $display("unexpected response transaction at %0t", $realtime);
               error_count++;
            end else begin
               want = expected_faces.pop_front();
               for (int i = 0; i < 3; i++) begin
                  if (rsp_tdata[16*i +: 16] !== want.normal[i])
                     report_mismatch($sformatf("normal[%0d]", i),
                                     rsp_tdata[16*i +: 16], want.normal[i]);
                  if (rsp_tdata[48 + 16*i +: 16] !== want.center[i])
                     report_mismatch($sformatf("center[%0d]", i),
                                     rsp_tdata[48 + 16*i +: 16], want.center[i]);
               end
               if (rsp_tuser !== want.degen)
                  report_mismatch("degenerate", 16'(rsp_tuser), 16'(want.degen));
            end
         end
         if (ready_left == 0) begin
            ready_mode = $urandom_range(2);
            ready_left = $urandom_range(60, 5);
         end
         ready_left--;
         case (ready_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= ($urandom_range(1) == 1);
            end
            default: begin
               rsp_tready <= (ready_left % 8 == 0);
            end
         endcase
      end
   end

   initial begin
      int ax;
      int ay;
      int az;
      int bx;
      int by;
      int bz;
      int k;
      int kind;
      // Directed part: degenerate cases, axis-aligned faces, extremes.
      add_face(0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_face(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      add_face(0, 0, 0, 256, 256, 256, 512, 512, 512);
      add_face(0, 0, 0, 256, 0, 0, 0, 256, 0);
      add_face(0, 0, 0, 0, 256, 0, 256, 0, 0);
      add_face(0, 0, 0, 0, 256, 0, 0, 0, 256);
      add_face(0, 0, 0, 0, 0, 256, 256, 0, 0);
      add_face(0, 0, 0, 1, 0, 0, 0, 1, 0);
      add_face(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
      add_face(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
      add_face(-32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768, 32767);
      add_face(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
      add_face(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      add_face(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768);
      add_face(100, 200, 300, 101, 200, 300, 100, 201, 301);
      add_face(0, 0, 0, 1, 1, 1, 2, 2, 1);
      add_face(-1, -1, -1, -1, -1, -2, -2, -1, -1);
      add_face(32767, 0, -32768, -32768, 32767, 0, 0, -32768, 32767);
      add_face(1, 2, 3, 3, 2, 1, 2, 3, 1);
      add_face(-5, 7, -9, -5, 7, -9, 30, -40, 50);

      // Random part: about half full-range faces, the rest small faces and
      // collinear triples.
      for (int n = 0; n < 750; n++) begin
         kind = $urandom_range(9);
         ax = rand_coord();
         ay = rand_coord();
         az = rand_coord();
         if (kind < 5) begin
            add_face(ax, ay, az, rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_coord());
         end else if (kind < 8) begin
            ax = ax / 2;
            ay = ay / 2;
            az = az / 2;
            add_face(ax, ay, az,
                     ax + int'($urandom_range(64)) - 32, ay + int'($urandom_range(64)) - 32,
                     az + int'($urandom_range(64)) - 32,
                     ax + int'($urandom_range(64)) - 32, ay + int'($urandom_range(64)) - 32,
                     az + int'($urandom_range(64)) - 32);
         end else begin
            // C = A + k * (B - A), kept in range, so the face is collinear.
            ax = ax / 4;
            ay = ay / 4;
            az = az / 4;
            bx = int'($urandom_range(400)) - 200;
            by = int'($urandom_range(400)) - 200;
            bz = int'($urandom_range(400)) - 200;
            k  = int'($urandom_range(20)) - 10;
            add_face(ax, ay, az, ax + bx, ay + by, az + bz,
                     ax + k * bx, ay + k * by, az + k * bz);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (pending_faces.size() == 0 && !req_tvalid);
      wait (expected_faces.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: sim.f
rtl/tnc_pkg.sv
rtl/tnc_front.sv
rtl/tnc_norm_step.sv
rtl/triangle_normal_and_centroid_top.sv
dv/triangle_normal_and_centroid_top_tb.sv
